@@ sv/plist_pkg.sv @@
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and codes for the positional list store: operation and status
// codes, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int POS_W  = 11;
  localparam int WORD_W = 64;
  localparam int STAT_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // latch the incoming item and its checked status
    logic ins_step;   // move one entry up by one place
    logic ins_write;  // write the new word at its position, bump the count
    logic rmv_get;    // read the entry being taken out
    logic rmv_cap;    // capture that entry as the result word
    logic rmv_step;   // move one entry down by one place
    logic rmv_fin;    // drop the count
    logic load_out;   // copy the result into the output register
  } plist_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_ok;      // incoming item passes its checks
    logic op_insert;  // incoming item is an insert
    logic ins_more;   // entries still to move up
    logic rmv_more;   // entries still to move down
    logic out_free;   // output register can take a result this cycle
    logic pend;       // a moved entry is due to be written this cycle
  } plist_sts_t;

endpackage

@@ sv/positional_list_insert_remove.sv @@
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// Ordered list store of up to CAPACITY 64-bit entry words, kept packed in
// one memory. Insert before a position (append at the count) or remove at a
// position, one result per item.
// ----------------------------------------------------------------------------
//
//  channel  handshake             fields
//  -------  --------------------  -------------------------------------------
//  in       in_valid / in_stall   opcode, position, item_value
//  out      out_valid / out_stall status, removed_item, entry_count
//
//  An insert at p moves the entries from p on up one place, then writes
//  the word; a remove takes entry p (p the entry taken) and moves the tail
//  down; a rejected item goes straight to its result. The single write port
//  moves one entry a cycle, so the shift of the tail sets the time taken.
//  Reset clears the count and the handshake state only; memory holds
//  whatever it held, and no entry is read before it is written.
//  A stalled output holds its result; the next input transfer is still
//  taken, and its result waits in the datapath until the output frees.
// ----------------------------------------------------------------------------
module positional_list_insert_remove import plist_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [POS_W-1:0]    position,
  input  logic [WORD_W-1:0]   item_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   status,
  output logic [WORD_W-1:0]   removed_item,
  output logic [POS_W-1:0]    entry_count
);

  plist_cmd_t cmd;
  plist_sts_t sts;

  // Sequence each item: check, walk the tail, then hand over the result.
  plist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the entries, the count and the result registers.
  plist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .position     (position),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .removed_item (removed_item),
    .entry_count  (entry_count)
  );

`ifndef SYNTH
  // One item at a time: after an input transfer the input stalls.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // The single write port never sees a moved entry and the new word together.
  a_wr_port: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins_write && sts.pend))
    else $error("two writes to the entry memory in one cycle");

  // A result is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result overwrote one still waiting on the output");
`endif

endmodule

@@ sv/plist_dp.sv @@
// ----------------------------------------------------------------------------
// plist_dp
// Datapath: entry memory with one write and one registered read port, the
// entry count, the walk index and the result and output registers.
// ----------------------------------------------------------------------------
module plist_dp import plist_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  plist_cmd_t          cmd,
  output plist_sts_t          sts,
  input  logic                opcode,
  input  logic [POS_W-1:0]    position,
  input  logic [WORD_W-1:0]   item_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STAT_W-1:0]   status,
  output logic [WORD_W-1:0]   removed_item,
  output logic [POS_W-1:0]    entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rdata;

  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     pos_r;
  logic [WORD_W-1:0] word_r;
  logic [STAT_W-1:0] res_status;
  logic [WORD_W-1:0] res_removed;
  logic              pend;
  logic [AW-1:0]     pend_addr;

  logic [MW-1:0]     pos_ext;
  logic [MW-1:0]     cnt_ext;
  logic [CW-1:0]     idx_dec;
  logic [CW-1:0]     pos_eff;
  status_t           chk;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  assign pos_ext = MW'(position);
  assign cnt_ext = MW'(count);
  assign idx_dec = idx - CW'(1);

  // Check the incoming item against the current count.
  always_comb begin
    chk = ST_OK;
    if (opcode == OP_INSERT) begin
      if (count == CW'(CAPACITY)) chk = ST_FULL;
      else if (pos_ext > cnt_ext) chk = ST_RANGE;
    end else begin
      if (count == '0) chk = ST_EMPTY;
      else if (pos_ext > cnt_ext) chk = ST_RANGE;
    end
  end

  // A remove at the count takes the last entry.
  always_comb begin
    if (opcode == OP_REMOVE && pos_ext == cnt_ext) pos_eff = count - CW'(1);
    else pos_eff = pos_ext[CW-1:0];
  end

  assign rd_en   = cmd.ins_step & sts.ins_more | cmd.rmv_get | cmd.rmv_step & sts.rmv_more;
  assign rd_addr = cmd.ins_step ? idx_dec[AW-1:0] : idx[AW-1:0];
  assign wr_en   = pend | cmd.ins_write;
  assign wr_addr = cmd.ins_write ? pos_r[AW-1:0] : pend_addr;
  assign wr_data = cmd.ins_write ? word_r : rdata;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= (cmd.ins_step & sts.ins_more) | (cmd.rmv_step & sts.rmv_more);
      if (cmd.ins_write) count <= count + CW'(1);
      if (cmd.rmv_fin)   count <= count - CW'(1);
      if (cmd.load_out)  out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_r      <= item_value;
      pos_r       <= pos_eff;
      res_status  <= chk;
      res_removed <= '0;
      idx         <= (opcode == OP_INSERT) ? count : pos_eff;
    end
    if (cmd.ins_step && sts.ins_more) begin
      pend_addr <= idx[AW-1:0];
      idx       <= idx_dec;
    end
    if (cmd.rmv_get) idx <= idx + CW'(1);
    if (cmd.rmv_cap) res_removed <= rdata;
    if (cmd.rmv_step && sts.rmv_more) begin
      pend_addr <= idx_dec[AW-1:0];
      idx       <= idx + CW'(1);
    end
    if (cmd.load_out) begin
      status       <= res_status;
      removed_item <= res_removed;
      entry_count  <= cnt_ext[POS_W-1:0];
    end
  end

  assign sts.op_ok     = (chk == ST_OK);
  assign sts.op_insert = (opcode == OP_INSERT);
  assign sts.ins_more  = (idx != pos_r);
  assign sts.rmv_more  = (idx < count);
  assign sts.out_free  = !out_valid || !out_stall;
  assign sts.pend      = pend;

endmodule

@@ sv/plist_ctrl.sv @@
// ----------------------------------------------------------------------------
// plist_ctrl
// Controller: sequences one insert or remove at a time over the datapath.
// ----------------------------------------------------------------------------
module plist_ctrl import plist_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  plist_sts_t sts,
  output plist_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_INS  = 9'b000000010,
    S_INSW = 9'b000000100,
    S_RGET = 9'b000001000,
    S_RCAP = 9'b000010000,
    S_RMV  = 9'b000100000,
    S_RFIN = 9'b001000000,
    S_DONE = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!sts.op_ok)        state_next = S_DONE;
          else if (sts.op_insert) state_next = S_INS;
          else                   state_next = S_RGET;
        end
      end
      S_INS: begin
        cmd.ins_step = 1'b1;
        if (!sts.ins_more) state_next = S_INSW;
      end
      S_INSW: begin
        cmd.ins_write = 1'b1;
        state_next    = S_DONE;
      end
      S_RGET: begin
        cmd.rmv_get = 1'b1;
        state_next  = S_RCAP;
      end
      S_RCAP: begin
        cmd.rmv_cap = 1'b1;
        state_next  = S_RMV;
      end
      S_RMV: begin
        cmd.rmv_step = 1'b1;
        if (!sts.rmv_more) state_next = S_RFIN;
      end
      S_RFIN: begin
        cmd.rmv_fin = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

@@ bench/plist_outcome_monitor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plist_outcome_monitor
// Watches both channels of the positional list store, keeps a shadow copy of
// the list, works out the outcome of every input transfer and compares each
// output transfer field by field with the oldest outcome still owed.
// ----------------------------------------------------------------------------
module plist_outcome_monitor import plist_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                opcode,
  input  logic [POS_W-1:0]    position,
  input  logic [WORD_W-1:0]   item_value,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STAT_W-1:0]   status,
  input  logic [WORD_W-1:0]   removed_item,
  input  logic [POS_W-1:0]    entry_count,
  output logic [POS_W-1:0]    list_len,
  output int                  pending,
  output int                  results_checked,
  output int                  fail_count
);

  typedef struct packed {
    status_t             st;
    logic [WORD_W-1:0]   word;
    logic [POS_W-1:0]    cnt;
  } list_outcome_t;

  logic [WORD_W-1:0] shadow_list[$];
  list_outcome_t     owed_outcomes[$];

  // Apply one operation to the shadow list and return what the block owes.
  function automatic list_outcome_t apply_list_op(input logic op,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [WORD_W-1:0] word);
    list_outcome_t o;
    int n;
    int p;
    n = shadow_list.size();
    p = int'(pos);
    o.st = ST_OK;
    o.word = '0;
    if (op == OP_INSERT) begin
      if (n >= CAPACITY) o.st = ST_FULL;
      else if (p > n) o.st = ST_RANGE;
      else shadow_list.insert(p, word);
    end else begin
      if (n == 0) o.st = ST_EMPTY;
      else if (p > n) o.st = ST_RANGE;
      else begin
        // a position equal to the length takes the last entry
        if (p == n) p = n - 1;
        o.word = shadow_list[p];
        shadow_list.delete(p);
      end
    end
    o.cnt = POS_W'(shadow_list.size());
    return o;
  endfunction

  always @(posedge clk) begin : watch
    list_outcome_t want;
    int errs;
    errs = 0;
    if (rst) begin
      shadow_list.delete();
      owed_outcomes.delete();
      results_checked <= 0;
      fail_count <= 0;
    end else begin
      // compare before predicting: a result never belongs to this edge's input
      if (out_valid && !out_stall) begin
        if (owed_outcomes.size() == 0) begin
          $error("unexpected result: status %0d removed_item %h entry_count %0d",
                 status, removed_item, entry_count);
          errs++;
        end else begin
          want = owed_outcomes.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            errs++;
          end
          if (removed_item !== want.word) begin
            $error("removed_item: expected %h, actual %h", want.word, removed_item);
            errs++;
          end
          if (entry_count !== want.cnt) begin
            $error("entry_count: expected %0d, actual %0d", want.cnt, entry_count);
            errs++;
          end
        end
        results_checked <= results_checked + 1;
      end
      if (in_valid && !in_stall)
        owed_outcomes.push_back(apply_list_op(opcode, position, item_value));
      fail_count <= fail_count + errs;
    end
    pending <= owed_outcomes.size();
    list_len <= POS_W'(shadow_list.size());
  end

endmodule

@@ bench/positional_list_insert_remove_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_insert_remove_tb
// Drives inserts and removes into the positional list store and leaves the
// checking to the outcome monitor. A directed opening covers the empty and
// out-of-range cases and the list ends; random traffic follows under three
// idling patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_tb;
  import plist_pkg::*;

  localparam int CAPACITY    = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 2_000_000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                opcode = OP_INSERT;
  logic [POS_W-1:0]    position = '0;
  logic [WORD_W-1:0]   item_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [WORD_W-1:0]   removed_item;
  logic [POS_W-1:0]    entry_count;

  logic [POS_W-1:0]    list_len;
  int                  pending;
  int                  results_checked;
  int                  fail_count;

  // idling percentages, changed between phases by the stimulus
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  // long hold-off request, picked up once by the receiver process
  logic                hold_req = 1'b0;
  logic                hold_taken = 1'b0;
  int                  hold_left = 0;
  int                  n_insert = 0;
  int                  n_remove = 0;
  int                  cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_list_insert_remove #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .position     (position),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .removed_item (removed_item),
    .entry_count  (entry_count)
  );

  plist_outcome_monitor #(.CAPACITY(CAPACITY)) outcome_mon (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .position        (position),
    .item_value      (item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .removed_item    (removed_item),
    .entry_count     (entry_count),
    .list_len        (list_len),
    .pending         (pending),
    .results_checked (results_checked),
    .fail_count      (fail_count)
  );

  // Receiver: stall at random, or hold off for a counted stretch on request.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("positional_list_insert_remove_tb: errors");
    $finish;
  end

  // Entry word: mostly random, with the all-zero and all-one extremes now and then.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offer one item from a falling edge, hold it until the transfer, and
  // return on the following falling edge.
  task automatic send_item(input logic op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    position   <= pos;
    item_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_INSERT) n_insert++;
    else n_remove++;
    @(negedge clk);
  endtask

  // Random traffic: mostly well-formed operations that keep the list near
  // size_hint entries, with some noise and some just-out-of-range positions.
  task automatic run_random(input int n, input int size_hint);
    int len;
    int roll;
    logic op;
    logic [POS_W-1:0] pos;
    repeat (n) begin
      len = int'(list_len);
      roll = $urandom_range(99);
      if (roll < 8) begin
        op = 1'($urandom_range(1));
        pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
      end else if (roll < 13) begin
        op = 1'($urandom_range(1));
        pos = POS_W'(len + 1 + int'($urandom_range(0, 2)));
      end else begin
        op = (len == 0 || $urandom_range(size_hint - 1) >= len) ? OP_INSERT : OP_REMOVE;
        case ($urandom_range(3))
          0:       pos = '0;
          1:       pos = POS_W'(len);
          default: pos = POS_W'($urandom_range(0, len));
        endcase
      end
      send_item(op, pos, pick_word());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase one: sender idles lightly, receiver heavily.
    send_idle_pct = 29;
    recv_idle_pct = 68;

    // Directed opening on an empty list.
    send_item(OP_REMOVE, '0, '1);                      // remove from empty
    send_item(OP_REMOVE, '1, '0);                      // empty beats range
    send_item(OP_INSERT, POS_W'(1), '1);               // insert past the end
    send_item(OP_INSERT, '1, '1);
    send_item(OP_INSERT, '0, '1);                      // first entry
    send_item(OP_INSERT, POS_W'(1), '0);               // append
    send_item(OP_INSERT, '0, {32{2'b01}});             // new head
    send_item(OP_INSERT, POS_W'(1), {32{2'b10}});      // middle
    send_item(OP_REMOVE, POS_W'(5), '0);               // past the count
    send_item(OP_REMOVE, POS_W'(4), '0);               // at the count: last entry
    send_item(OP_REMOVE, POS_W'(1), '0);               // middle
    send_item(OP_REMOVE, '0, '0);                      // head
    send_item(OP_REMOVE, POS_W'(1), '0);               // at the count, one left
    send_item(OP_REMOVE, '0, '0);                      // empty again
    send_item(OP_INSERT, '0, pick_word());
    send_item(OP_INSERT, POS_W'(CAPACITY), pick_word()); // top position bit, out of range
    send_item(OP_REMOVE, POS_W'(CAPACITY), pick_word());

    run_random(190, 8);

    // Phase two: the other way round.
    send_idle_pct = 68;
    recv_idle_pct = 29;
    run_random(190, 64);

    // Phase three: no idling; open with a long hold-off so the block backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    run_random(190, 200);

    // Drop valid, collect the outstanding results, then watch for strays.
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (CAPACITY + 16) @(negedge clk);

    $display("Drove %0d inserts and %0d removes, checked %0d results;",
             n_insert, n_remove, results_checked);
    $display("empty, range and list-end cases plus random traffic, three stall patterns.");
    if (fail_count == 0) begin
      $display("positional_list_insert_remove_tb: clean");
    end else begin
      $display("positional_list_insert_remove_tb: errors");
    end
    $finish;
  end

endmodule
